[design/nfa_to_dfa_subset_builder_assert.svh]
// assertion macros used by the checker file
`ifndef NFA_TO_DFA_SUBSET_BUILDER_ASSERT_SVH
`define NFA_TO_DFA_SUBSET_BUILDER_ASSERT_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define N2D_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("n2d check failed");

// next-cycle implication
`define N2D_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("n2d check failed");

`endif

[design/n2d_pkg.sv]
`default_nettype none
package n2d_pkg;

  localparam int NfaStates   = 32;
  localparam int NfaW        = 5;
  localparam int SymW        = 8;
  localparam int TransW      = 2 * NfaW + SymW;

  localparam int MaxTransDef = 64;
  localparam int MaxSymDef   = 16;
  localparam int DfaStatesDef = 64;

  localparam logic [SymW-1:0] LambdaReset = 8'd108;

  localparam logic [2:0] ReqClear = 3'd0;
  localparam logic [2:0] ReqTrans = 3'd1;
  localparam logic [2:0] ReqFinal = 3'd2;
  localparam logic [2:0] ReqSym   = 3'd3;
  localparam logic [2:0] ReqBuild = 3'd4;
  localparam logic [2:0] ReqQuery = 3'd5;

  localparam logic [1:0] StOk         = 2'd0;
  localparam logic [1:0] StFull       = 2'd1;
  localparam logic [1:0] StOverflow   = 2'd2;
  localparam logic [1:0] StQueryRange = 2'd3;

  localparam int CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgStart  = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgLambda = 1'd1;

  typedef struct packed {
    logic            start;
    logic            closure;
    logic [SymW-1:0] key;
  } scan_req_t;

endpackage
`default_nettype wire

[design/n2d_trans_scan.sv]
`default_nettype none
// transition store plus the shared scan unit: one pass reads one transition a cycle,
// closure mode repeats passes until the set stops growing
module n2d_trans_scan #(
  parameter int MaxTrans = n2d_pkg::MaxTransDef
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              wr_en_i,
  input  wire logic [n2d_pkg::TransW-1:0]        wr_data_i,
  input  wire logic [$clog2(MaxTrans+1)-1:0]     tcount_i,
  input  wire n2d_pkg::scan_req_t                req_i,
  input  wire logic [n2d_pkg::NfaStates-1:0]     src_i,
  input  wire logic [n2d_pkg::NfaStates-1:0]     init_i,
  output logic                                   done_o,
  output logic [n2d_pkg::NfaStates-1:0]          acc_o
);

  localparam int TCW = $clog2(MaxTrans + 1);
  localparam int TAW = (MaxTrans > 1) ? $clog2(MaxTrans) : 1;
  localparam int NW  = n2d_pkg::NfaW;
  localparam int SW  = n2d_pkg::SymW;

  logic [n2d_pkg::TransW-1:0]   mem [MaxTrans];
  logic [n2d_pkg::TransW-1:0]   rd_q;
  logic                         run_q, vld_q, changed_q, clos_q, done_q;
  logic [TCW-1:0]               addr_q;
  logic [n2d_pkg::NfaStates-1:0] acc_q, src_q;
  logic [SW-1:0]                key_q;

  logic [NW-1:0]                t_from, t_to;
  logic [SW-1:0]                t_sym;
  logic [n2d_pkg::NfaStates-1:0] look, bit_to;
  logic                         hit;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[tcount_i[TAW-1:0]] <= wr_data_i;
    end
    rd_q <= mem[addr_q[TAW-1:0]];
  end

  always_comb begin
    t_from = rd_q[n2d_pkg::TransW-1 -: NW];
    t_sym  = rd_q[NW +: SW];
    t_to   = rd_q[NW-1:0];
    look   = clos_q ? acc_q : src_q;
    bit_to = n2d_pkg::NfaStates'(1) << t_to;
    hit    = vld_q && (t_sym == key_q) && look[t_from];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q     <= 1'b0;
      vld_q     <= 1'b0;
      done_q    <= 1'b0;
      changed_q <= 1'b0;
      clos_q    <= 1'b0;
      addr_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        run_q     <= 1'b1;
        vld_q     <= 1'b0;
        changed_q <= 1'b0;
        clos_q    <= req_i.closure;
        addr_q    <= '0;
      end else if (run_q) begin
        vld_q <= (addr_q < tcount_i);
        if (addr_q < tcount_i) begin
          addr_q <= addr_q + TCW'(1);
        end
        if (hit && ((acc_q & bit_to) == '0)) begin
          changed_q <= 1'b1;
        end
        // pass finished once the last read word has been folded in
        if (!vld_q && (addr_q >= tcount_i)) begin
          if (clos_q && changed_q) begin
            addr_q    <= '0;
            changed_q <= 1'b0;
          end else begin
            run_q  <= 1'b0;
            done_q <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q <= init_i;
      src_q <= src_i;
      key_q <= req_i.key;
    end else if (hit) begin
      acc_q <= acc_q | bit_to;
    end
  end

  assign done_o = done_q;
  assign acc_o  = acc_q;

endmodule
`default_nettype wire

[design/nfa_to_dfa_subset_builder.sv]
// nfa to dfa subset builder
// input words on s_axis: tuser is the request (clear, add transition, add final,
// add symbol, build, query), tdata carries from_state, symbol, to_state, query_state.
// every input word gives exactly one result word on m_axis (tuser status, tdata
// dfa_count, next_id, has_next, is_final).
// config writes on cfg_*: index 0 start state, index 1 lambda symbol code; always ready.
// a load or clear word passes through the exec state to the resp state, an in-range
// query also through a table read wait state; no new word is taken in between.
// a build takes, per dfa state and alphabet symbol, one step pass over the stored
// transitions, then, if that set is not empty, closure passes until the set stops
// growing and a compare against the known sets in turn. the transition scan unit
// is the one shared engine.
// s_axis_tready is low from acceptance until the result enters the output register.
// the output register holds a result while m_axis_tready is low; the block then
// waits with s_axis_tready low until the register frees.
// reset empties the nfa, alphabet and dfa and restores start 0 and lambda 108.
`default_nettype none
module nfa_to_dfa_subset_builder #(
  parameter int MaxTrans  = n2d_pkg::MaxTransDef,
  parameter int MaxSym    = n2d_pkg::MaxSymDef,
  parameter int DfaStates = n2d_pkg::DfaStatesDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // from_state[4:0], symbol[12:5], to_state[17:13], query_state[23:18]
  input  wire logic [23:0]                  s_axis_tdata_i,
  // req_type[2:0]
  input  wire logic [2:0]                   s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  wire logic                         m_axis_tready_i,
  // dfa_count[6:0], next_id[12:7], has_next[13], is_final[14], zero[15]
  output logic [15:0]                       m_axis_tdata_o,
  // status[1:0]
  output logic [1:0]                        m_axis_tuser_o,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [n2d_pkg::CfgIdxW-1:0]  cfg_addr_i,
  input  wire logic [7:0]                   cfg_data_i
);

  localparam int TCW = $clog2(MaxTrans + 1);
  localparam int SAW = (MaxSym > 1) ? $clog2(MaxSym) : 1;
  localparam int SCW = $clog2(MaxSym + 1);
  localparam int DAW = $clog2(DfaStates);
  localparam int DCW = $clog2(DfaStates + 1);
  localparam int QCW = DCW + 6;
  localparam int NS  = n2d_pkg::NfaStates;
  localparam int NW  = n2d_pkg::NfaW;
  localparam int SW  = n2d_pkg::SymW;
  localparam int TblDepth = DfaStates << SAW;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EXEC  = 4'd1;
  localparam logic [3:0] S_CLO0  = 4'd2;
  localparam logic [3:0] S_ITER  = 4'd3;
  localparam logic [3:0] S_LOAD  = 4'd4;
  localparam logic [3:0] S_LOADW = 4'd5;
  localparam logic [3:0] S_STEP  = 4'd6;
  localparam logic [3:0] S_CLOS  = 4'd7;
  localparam logic [3:0] S_SRCH  = 4'd8;
  localparam logic [3:0] S_SRCHW = 4'd9;
  localparam logic [3:0] S_QRYW  = 4'd10;
  localparam logic [3:0] S_RESP  = 4'd11;

  logic [3:0]     state_q;
  logic [2:0]     req_q;
  logic [NW-1:0]  from_q, to_q, start_q;
  logic [SW-1:0]  sym_q, lambda_q;
  logic [5:0]     qst_q;

  logic [TCW-1:0] tcount_q;
  logic [NS-1:0]  final_mask_q;
  logic [SW-1:0]  alph_q [MaxSym];
  logic [SCW-1:0] alph_cnt_q, built_q, j_q;
  logic [DCW-1:0] dfa_cnt_q, i_q, k_q;
  logic [NS-1:0]  s_q;
  logic           qfound_q;

  logic [1:0]     res_status_q;
  logic [5:0]     res_next_q;
  logic           res_has_q, res_fin_q;

  logic           m_valid_q;
  logic [1:0]     m_status_q;
  logic [6:0]     m_count_q;
  logic [5:0]     m_next_q;
  logic           m_has_q, m_fin_q;
  logic           m_load;

  // dfa storage
  logic [NS-1:0]  sets_mem [DfaStates];
  logic           final_mem [DfaStates];
  logic [DAW:0]   tbl_mem [TblDepth];
  logic [NS-1:0]  set_rd_q;
  logic           final_rd_q;
  logic [DAW:0]   tbl_rd_q;

  logic           set_we, tbl_we, tr_we;
  logic [DAW-1:0] set_wa, set_ra;
  logic [NS-1:0]  set_wd;
  logic [DAW+SAW-1:0] tbl_wa;
  logic [DAW:0]   tbl_wd;

  n2d_pkg::scan_req_t scan_req;
  logic [NS-1:0]  scan_init, scan_acc;
  logic           scan_done;

  logic           dup, qhit, in_acc, room, q_in;
  logic [SAW-1:0] qsel;

  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign room            = (dfa_cnt_q < DCW'(DfaStates));
  assign q_in            = (QCW'(qst_q) < QCW'(dfa_cnt_q));
  assign m_load          = (state_q == S_RESP) && (!m_valid_q || m_axis_tready_i);

  // symbol lookups against the alphabet, compared in parallel
  always_comb begin
    dup  = 1'b0;
    qhit = 1'b0;
    qsel = '0;
    for (int j = 0; j < MaxSym; j++) begin
      if ((SCW'(j) < alph_cnt_q) && (alph_q[j] == sym_q)) begin
        dup = 1'b1;
      end
    end
    for (int j = MaxSym - 1; j >= 0; j--) begin
      if ((SCW'(j) < built_q) && (alph_q[j] == sym_q)) begin
        qhit = 1'b1;
        qsel = SAW'(j);
      end
    end
  end

  // scan unit requests
  always_comb begin
    scan_req  = '0;
    scan_init = '0;
    case (state_q)
      S_EXEC: begin
        if (req_q == n2d_pkg::ReqBuild) begin
          scan_req.start   = 1'b1;
          scan_req.closure = 1'b1;
          scan_req.key     = lambda_q;
          scan_init        = NS'(1) << start_q;
        end
      end
      S_LOADW: begin
        scan_req.start = 1'b1;
        scan_req.key   = alph_q[j_q[SAW-1:0]];
      end
      S_STEP: begin
        if (scan_done && (scan_acc != '0)) begin
          scan_req.start   = 1'b1;
          scan_req.closure = 1'b1;
          scan_req.key     = lambda_q;
          scan_init        = scan_acc;
        end
      end
      default: begin
      end
    endcase
  end

  assign tr_we = (state_q == S_EXEC) && (req_q == n2d_pkg::ReqTrans)
                 && (tcount_q < TCW'(MaxTrans));

  n2d_trans_scan #(
    .MaxTrans (MaxTrans)
  ) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (tr_we),
    .wr_data_i ({from_q, sym_q, to_q}),
    .tcount_i  (tcount_q),
    .req_i     (scan_req),
    .src_i     (set_rd_q),
    .init_i    (scan_init),
    .done_o    (scan_done),
    .acc_o     (scan_acc)
  );

  // dfa memory control
  always_comb begin
    set_we = 1'b0;
    set_wa = dfa_cnt_q[DAW-1:0];
    set_wd = s_q;
    tbl_we = 1'b0;
    tbl_wd = '0;
    tbl_wa = {i_q[DAW-1:0], j_q[SAW-1:0]};
    set_ra = (state_q == S_LOAD) ? i_q[DAW-1:0] : k_q[DAW-1:0];
    case (state_q)
      S_CLO0: begin
        set_we = scan_done;
        set_wa = '0;
        set_wd = scan_acc;
      end
      S_STEP: begin
        tbl_we = scan_done && (scan_acc == '0);
      end
      S_SRCH: begin
        if ((k_q == dfa_cnt_q) && room) begin
          set_we = 1'b1;
          tbl_we = 1'b1;
          tbl_wd = {1'b1, dfa_cnt_q[DAW-1:0]};
        end
      end
      S_SRCHW: begin
        if (set_rd_q == s_q) begin
          tbl_we = 1'b1;
          tbl_wd = {1'b1, k_q[DAW-1:0]};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (set_we) begin
      sets_mem[set_wa]  <= set_wd;
      final_mem[set_wa] <= ((set_wd & final_mask_q) != '0);
    end
    if (tbl_we) begin
      tbl_mem[tbl_wa] <= tbl_wd;
    end
    set_rd_q   <= sets_mem[set_ra];
    final_rd_q <= final_mem[DAW'(qst_q)];
    tbl_rd_q   <= tbl_mem[{DAW'(qst_q), qsel}];
  end

  // input fields and working set, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q  <= s_axis_tuser_i;
      from_q <= s_axis_tdata_i[4:0];
      sym_q  <= s_axis_tdata_i[12:5];
      to_q   <= s_axis_tdata_i[17:13];
      qst_q  <= s_axis_tdata_i[23:18];
    end
    if (state_q == S_CLOS && scan_done) begin
      s_q <= scan_acc;
    end
    if (state_q == S_EXEC && req_q == n2d_pkg::ReqSym && !dup
        && (alph_cnt_q < SCW'(MaxSym))) begin
      alph_q[alph_cnt_q[SAW-1:0]] <= sym_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      start_q      <= '0;
      lambda_q     <= n2d_pkg::LambdaReset;
      tcount_q     <= '0;
      final_mask_q <= '0;
      alph_cnt_q   <= '0;
      built_q      <= '0;
      dfa_cnt_q    <= '0;
      i_q          <= '0;
      j_q          <= '0;
      k_q          <= '0;
      qfound_q     <= 1'b0;
      res_status_q <= n2d_pkg::StOk;
      res_next_q   <= '0;
      res_has_q    <= 1'b0;
      res_fin_q    <= 1'b0;
      m_valid_q    <= 1'b0;
      m_status_q   <= n2d_pkg::StOk;
      m_count_q    <= '0;
      m_next_q     <= '0;
      m_has_q      <= 1'b0;
      m_fin_q      <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_addr_i)
          n2d_pkg::CfgStart:  start_q  <= cfg_data_i[NW-1:0];
          n2d_pkg::CfgLambda: lambda_q <= cfg_data_i;
          default: begin
          end
        endcase
      end

      if (m_load) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_next_q <= '0;
          res_has_q  <= 1'b0;
          res_fin_q  <= 1'b0;
          case (req_q)
            n2d_pkg::ReqClear: begin
              tcount_q     <= '0;
              final_mask_q <= '0;
              alph_cnt_q   <= '0;
              built_q      <= '0;
              dfa_cnt_q    <= '0;
              res_status_q <= n2d_pkg::StOk;
              state_q      <= S_RESP;
            end
            n2d_pkg::ReqTrans: begin
              state_q <= S_RESP;
              if (tr_we) begin
                tcount_q     <= tcount_q + TCW'(1);
                res_status_q <= n2d_pkg::StOk;
              end else begin
                res_status_q <= n2d_pkg::StFull;
              end
            end
            n2d_pkg::ReqFinal: begin
              final_mask_q <= final_mask_q | (NS'(1) << from_q);
              res_status_q <= n2d_pkg::StOk;
              state_q      <= S_RESP;
            end
            n2d_pkg::ReqSym: begin
              state_q <= S_RESP;
              if (!dup && (alph_cnt_q >= SCW'(MaxSym))) begin
                res_status_q <= n2d_pkg::StFull;
              end else begin
                res_status_q <= n2d_pkg::StOk;
              end
              if (!dup && (alph_cnt_q < SCW'(MaxSym))) begin
                alph_cnt_q <= alph_cnt_q + SCW'(1);
              end
            end
            n2d_pkg::ReqBuild: begin
              built_q      <= alph_cnt_q;
              res_status_q <= n2d_pkg::StOk;
              state_q      <= S_CLO0;
            end
            n2d_pkg::ReqQuery: begin
              if (q_in) begin
                qfound_q     <= qhit;
                res_status_q <= n2d_pkg::StOk;
                state_q      <= S_QRYW;
              end else begin
                res_status_q <= n2d_pkg::StQueryRange;
                state_q      <= S_RESP;
              end
            end
            default: begin
              res_status_q <= n2d_pkg::StOk;
              state_q      <= S_RESP;
            end
          endcase
        end
        S_CLO0: begin
          if (scan_done) begin
            dfa_cnt_q <= DCW'(1);
            i_q       <= '0;
            j_q       <= '0;
            state_q   <= S_ITER;
          end
        end
        S_ITER: begin
          if (i_q == dfa_cnt_q) begin
            state_q <= S_RESP;
          end else if (j_q == built_q) begin
            i_q <= i_q + DCW'(1);
            j_q <= '0;
          end else begin
            state_q <= S_LOAD;
          end
        end
        S_LOAD: begin
          state_q <= S_LOADW;
        end
        S_LOADW: begin
          state_q <= S_STEP;
        end
        S_STEP: begin
          if (scan_done) begin
            if (scan_acc == '0) begin
              j_q     <= j_q + SCW'(1);
              state_q <= S_ITER;
            end else begin
              state_q <= S_CLOS;
            end
          end
        end
        S_CLOS: begin
          if (scan_done) begin
            k_q     <= '0;
            state_q <= S_SRCH;
          end
        end
        S_SRCH: begin
          if (k_q == dfa_cnt_q) begin
            if (room) begin
              dfa_cnt_q <= dfa_cnt_q + DCW'(1);
              j_q       <= j_q + SCW'(1);
              state_q   <= S_ITER;
            end else begin
              dfa_cnt_q    <= '0;
              res_status_q <= n2d_pkg::StOverflow;
              state_q      <= S_RESP;
            end
          end else begin
            state_q <= S_SRCHW;
          end
        end
        S_SRCHW: begin
          if (set_rd_q == s_q) begin
            j_q     <= j_q + SCW'(1);
            state_q <= S_ITER;
          end else begin
            k_q     <= k_q + DCW'(1);
            state_q <= S_SRCH;
          end
        end
        S_QRYW: begin
          res_fin_q <= final_rd_q;
          if (qfound_q && tbl_rd_q[DAW]) begin
            res_has_q  <= 1'b1;
            res_next_q <= 6'(tbl_rd_q[DAW-1:0]);
          end
          state_q <= S_RESP;
        end
        S_RESP: begin
          // result word moves into the output register once it is free
          if (m_load) begin
            m_status_q <= res_status_q;
            m_count_q  <= 7'(dfa_cnt_q);
            m_next_q   <= res_next_q;
            m_has_q    <= res_has_q;
            m_fin_q    <= res_fin_q;
            state_q    <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = m_status_q;
  assign m_axis_tdata_o  = {1'b0, m_fin_q, m_has_q, m_next_q, m_count_q};

endmodule
`default_nettype wire

[design/n2d_checker.sv]
`default_nettype none
`include "nfa_to_dfa_subset_builder_assert.svh"
module n2d_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [15:0] m_axis_tdata_o,
  input wire logic [1:0]  m_axis_tuser_o
);

  // a result word stays until taken
  `N2D_ASSERT_NXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o)

  // one word at a time: busy right after taking a word
  `N2D_ASSERT_NXT(a_busy_after_accept, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o)

  // a transition is only reported with an ok status
  `N2D_ASSERT_NOW(a_next_needs_ok, m_axis_tvalid_o && m_axis_tdata_o[13],
                  m_axis_tuser_o == n2d_pkg::StOk)

  // out of range queries carry no next state and no final flag
  `N2D_ASSERT_NOW(a_range_clean, m_axis_tvalid_o && (m_axis_tuser_o == n2d_pkg::StQueryRange),
                  m_axis_tdata_o[14:7] == 8'd0)

  // an overflowed build reports no states
  `N2D_ASSERT_NOW(a_overflow_zero, m_axis_tvalid_o && (m_axis_tuser_o == n2d_pkg::StOverflow),
                  m_axis_tdata_o[6:0] == 7'd0)

endmodule

bind nfa_to_dfa_subset_builder n2d_checker u_n2d_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 100ps
`default_nettype none

class nfa_result_board;
  logic [1:0]  exp_status[256];
  logic [15:0] exp_data[256];
  int          wr_ptr;
  int          rd_ptr;
  int          errors;
  int          mismatches;

  function void note_word(logic [1:0] status, logic [15:0] data);
    exp_status[wr_ptr % 256] = status;
    exp_data[wr_ptr % 256] = data;
    wr_ptr++;
  endfunction

  function void check_word(logic [1:0] status, logic [15:0] data);
    logic [1:0]  es;
    logic [15:0] ed;
    if (wr_ptr == rd_ptr) begin
      errors++;
      if (mismatches++ < 10) $display("unexpected result word %h/%h", status, data);
      return;
    end
    es = exp_status[rd_ptr % 256];
    ed = exp_data[rd_ptr % 256];
    rd_ptr++;
    if (es !== status || ed !== data) begin
      errors++;
      if (mismatches++ < 10)
        $display("mismatch: status exp %0d got %0d, data exp %h got %h", es, status, ed, data);
    end
  endfunction

  function int pending();
    return wr_ptr - rd_ptr;
  endfunction
endclass

module tb_top;

  localparam int MaxTr  = 64;
  localparam int MaxSy  = 16;
  localparam int DfaMax = 64;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i = '0;
  logic [2:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [n2d_pkg::CfgIdxW-1:0] cfg_addr_i = '0;
  logic [7:0]  cfg_data_i = '0;

  always #5 clk_i = ~clk_i;

  nfa_to_dfa_subset_builder dut (.*);

  // predictor state
  logic [4:0]  start_st;
  logic [7:0]  lam;
  logic [4:0]  tr_from[MaxTr];
  logic [7:0]  tr_sym[MaxTr];
  logic [4:0]  tr_to[MaxTr];
  int          tr_cnt;
  logic [31:0] fin_mask;
  logic [7:0]  alpha[MaxSy];
  int          alpha_cnt;
  logic [31:0] sets[DfaMax];
  logic [6:0]  next_tab[DfaMax][MaxSy];
  bit          dfin[DfaMax];
  int          dcount;
  int          built_syms;

  nfa_result_board board = new();
  bit idle_on = 1'b1;

  function automatic logic [31:0] lambda_close(logic [31:0] s);
    bit grew;
    grew = 1'b1;
    while (grew) begin
      grew = 1'b0;
      for (int i = 0; i < tr_cnt; i++)
        if (tr_sym[i] == lam && s[tr_from[i]] && !s[tr_to[i]]) begin
          s[tr_to[i]] = 1'b1;
          grew = 1'b1;
        end
    end
    return s;
  endfunction

  function automatic logic [1:0] run_subset();
    int cnt;
    int k;
    logic [31:0] s;
    cnt = 1;
    sets[0] = lambda_close(32'd1 << start_st);
    built_syms = alpha_cnt;
    for (int i = 0; i < cnt; i++)
      for (int j = 0; j < built_syms; j++) begin
        s = '0;
        for (int t = 0; t < tr_cnt; t++)
          if (tr_sym[t] == alpha[j] && sets[i][tr_from[t]]) s[tr_to[t]] = 1'b1;
        s = lambda_close(s);
        next_tab[i][j] = '0;
        if (s != 0) begin
          k = 0;
          while (k < cnt && sets[k] != s) k++;
          if (k == cnt) begin
            if (cnt >= DfaMax) begin
              dcount = 0;
              return n2d_pkg::StOverflow;
            end
            sets[cnt] = s;
            cnt++;
          end
          next_tab[i][j] = {1'b1, 6'(k)};
        end
      end
    for (int i = 0; i < cnt; i++) dfin[i] = (sets[i] & fin_mask) != 0;
    dcount = cnt;
    return n2d_pkg::StOk;
  endfunction

  task automatic predict_word(logic [2:0] req, logic [23:0] d);
    logic [4:0] from_s;
    logic [7:0] sym;
    logic [4:0] to_s;
    logic [5:0] q;
    logic [1:0] st;
    logic [5:0] nid;
    bit hn;
    bit fl;
    bit dup;
    from_s = d[4:0];
    sym = d[12:5];
    to_s = d[17:13];
    q = d[23:18];
    st = n2d_pkg::StOk;
    nid = '0;
    hn = 1'b0;
    fl = 1'b0;
    case (req)
      n2d_pkg::ReqClear: begin
        tr_cnt = 0;
        fin_mask = '0;
        alpha_cnt = 0;
        dcount = 0;
        built_syms = 0;
      end
      n2d_pkg::ReqTrans: begin
        if (tr_cnt >= MaxTr) st = n2d_pkg::StFull;
        else begin
          tr_from[tr_cnt] = from_s;
          tr_sym[tr_cnt] = sym;
          tr_to[tr_cnt] = to_s;
          tr_cnt++;
        end
      end
      n2d_pkg::ReqFinal: fin_mask[from_s] = 1'b1;
      n2d_pkg::ReqSym: begin
        dup = 1'b0;
        for (int i = 0; i < alpha_cnt; i++) if (alpha[i] == sym) dup = 1'b1;
        if (!dup) begin
          if (alpha_cnt >= MaxSy) st = n2d_pkg::StFull;
          else begin
            alpha[alpha_cnt] = sym;
            alpha_cnt++;
          end
        end
      end
      n2d_pkg::ReqBuild: st = run_subset();
      n2d_pkg::ReqQuery: begin
        if (q >= dcount) st = n2d_pkg::StQueryRange;
        else begin
          fl = dfin[q];
          for (int j = 0; j < built_syms; j++)
            if (alpha[j] == sym) begin
              if (next_tab[q][j][6]) begin
                hn = 1'b1;
                nid = next_tab[q][j][5:0];
              end
              break;
            end
        end
      end
      default: ;
    endcase
    board.note_word(st, {1'b0, fl, hn, nid, 7'(dcount)});
  endtask

  task automatic send_word(logic [2:0] req, logic [4:0] f, logic [7:0] sym,
                           logic [4:0] t, logic [5:0] q);
    // the block is busy after each word until its result is registered, which hides part of this idle time
    @(posedge clk_i);
    while (idle_on && $urandom_range(99) < 22) @(posedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= req;
    s_axis_tdata_i <= {q, t, sym, f};
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_word(req, {q, t, sym, f});
    s_axis_tvalid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (board.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [n2d_pkg::CfgIdxW-1:0] idx, logic [7:0] val);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == n2d_pkg::CfgStart) start_st = val[4:0];
    else lam = val;
  endtask

  // a random nfa with random symbols and lambda edges
  task automatic random_nfa(int n_tr, int n_sym);
    send_word(n2d_pkg::ReqClear, 5'($urandom), 8'($urandom), 5'($urandom), 6'($urandom));
    for (int i = 0; i < n_sym; i++)
      send_word(n2d_pkg::ReqSym, '0, 8'($urandom_range(3)), '0, '0);
    for (int i = 0; i < n_tr; i++)
      send_word(n2d_pkg::ReqTrans, 5'($urandom_range(7)),
                ($urandom_range(3) == 0) ? lam : 8'($urandom_range(3)),
                5'($urandom_range(7)), 6'($urandom));
    send_word(n2d_pkg::ReqFinal, 5'($urandom_range(7)), 8'($urandom), '0, '0);
    send_word(n2d_pkg::ReqBuild, 5'($urandom), 8'($urandom), 5'($urandom), 6'($urandom));
    for (int i = 0; i < 4; i++)
      send_word(n2d_pkg::ReqQuery, 5'($urandom), 8'($urandom_range(4)), 5'($urandom),
                6'($urandom_range(7)));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) board.check_word(m_axis_tuser_o, m_axis_tdata_o);
      m_axis_tready_i <= !idle_on || ($urandom_range(99) >= 22);
    end
  end

  initial begin
    start_st = '0;
    lam = n2d_pkg::LambdaReset;
    tr_cnt = 0;
    fin_mask = '0;
    alpha_cnt = 0;
    dcount = 0;
    built_syms = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: tiny nfa with lambda edge, duplicates, extremes, unused codes
    send_word(n2d_pkg::ReqQuery, '0, '0, '0, 6'd63);
    send_word(n2d_pkg::ReqSym, '0, 8'd97, '0, '0);
    send_word(n2d_pkg::ReqSym, '0, 8'd97, '0, '0);
    send_word(n2d_pkg::ReqSym, '0, 8'd108, '0, '0);
    send_word(n2d_pkg::ReqTrans, 5'd0, 8'd97, 5'd1, '0);
    send_word(n2d_pkg::ReqTrans, 5'd1, 8'd108, 5'd31, '0);
    send_word(n2d_pkg::ReqTrans, 5'd1, 8'd108, 5'd31, '0);
    send_word(n2d_pkg::ReqFinal, 5'd31, '0, '0, '0);
    send_word(n2d_pkg::ReqBuild, '0, '0, '0, '0);
    send_word(n2d_pkg::ReqQuery, '0, 8'd97, '0, 6'd0);
    send_word(n2d_pkg::ReqQuery, '0, 8'd97, '0, 6'd1);
    send_word(n2d_pkg::ReqQuery, '0, 8'd255, '0, 6'd1);
    send_word(3'd6, 5'd31, 8'd255, 5'd31, 6'd63);
    send_word(3'd7, '0, '0, '0, '0);
    // fill the alphabet past full
    for (int i = 0; i < MaxSy + 1; i++) send_word(n2d_pkg::ReqSym, '0, 8'(200 + i), '0, '0);
    // load 53 transitions, below full: state counter makes > 64 dfa sets
    send_word(n2d_pkg::ReqClear, '0, '0, '0, '0);
    send_word(n2d_pkg::ReqSym, '0, 8'd1, '0, '0);
    send_word(n2d_pkg::ReqSym, '0, 8'd2, '0, '0);
    for (int i = 0; i < 5; i++) begin
      send_word(n2d_pkg::ReqTrans, 5'(i), 8'd1, 5'(i + 1), '0);
      send_word(n2d_pkg::ReqTrans, 5'(i), 8'd1, 5'(i), '0);
      send_word(n2d_pkg::ReqTrans, 5'(i), 8'd2, 5'(i + 6), '0);
      send_word(n2d_pkg::ReqTrans, 5'(i + 6), 8'd2, 5'(i + 6), '0);
      send_word(n2d_pkg::ReqTrans, 5'(i + 6), 8'd1, 5'(i), '0);
    end
    for (int i = 0; i < 6; i++) send_word(n2d_pkg::ReqTrans, 5'(i), 8'd2, 5'(i + 12), '0);
    for (int i = 12; i < 18; i++) send_word(n2d_pkg::ReqTrans, 5'(i), 8'd1, 5'(i - 11), '0);
    for (int i = 0; i < 15; i++) send_word(n2d_pkg::ReqTrans, 5'(i + 17), 8'd2, 5'(i), '0);
    send_word(n2d_pkg::ReqTrans, 5'd31, 8'd255, 5'd0, '0);
    send_word(n2d_pkg::ReqBuild, '0, '0, '0, '0);
    send_word(n2d_pkg::ReqQuery, '0, 8'd1, '0, 6'd0);

    write_reg(n2d_pkg::CfgStart, 8'd31);
    write_reg(n2d_pkg::CfgLambda, 8'd0);
    random_nfa(8, 3);
    write_reg(n2d_pkg::CfgStart, 8'($urandom_range(7)));
    write_reg(n2d_pkg::CfgLambda, 8'd255);
    random_nfa(10, 3);
    write_reg(n2d_pkg::CfgStart, 8'd0);
    write_reg(n2d_pkg::CfgLambda, 8'd2);
    idle_on = 1'b0;
    random_nfa(12, 4);
    idle_on = 1'b1;

    wait_drained();
    repeat (5000) @(posedge clk_i);
    if (board.errors == 0 && board.pending() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end
endmodule
`default_nettype wire
